// ===== hdl/mhe_pkg.sv =====
`timescale 1ns / 1ps

package mhe_pkg;

    // Fixed field widths
    localparam int COORD_W = 21;
    localparam int CODE_W  = 63;
    localparam int LEVEL_W = 5;
    localparam int STATE_W = 4;
    localparam int SEL_W   = 2;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 3;
    localparam int DATA_W  = 5;

    // Configuration register indexes
    typedef enum logic [INDEX_W-1:0] {
        CFG_CURVE_MODE   = 3'd0,
        CFG_X_SOURCE     = 3'd1,
        CFG_Y_SOURCE     = 3'd2,
        CFG_Z_SOURCE     = 3'd3,
        CFG_HILBERT_BITS = 3'd4
    } t_cfg_reg;

    // Curve modes; any other code emits zero
    localparam logic [MODE_W-1:0] MODE_MORTON  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HILBERT = 2'd1;

    // Axis source selects; any other code reads as zero
    localparam logic [SEL_W-1:0] SRC_FIRST  = 2'd0;
    localparam logic [SEL_W-1:0] SRC_SECOND = 2'd1;
    localparam logic [SEL_W-1:0] SRC_THIRD  = 2'd2;

    localparam int HIL_STATES = 12;

    // Hilbert walk table: 3-bit index emitted, by state and octant
    localparam logic [2:0] HIL_IDX [HIL_STATES][8] = '{
        '{3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5},
        '{3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd5},
        '{3'd0, 3'd3, 3'd7, 3'd4, 3'd1, 3'd2, 3'd6, 3'd5},
        '{3'd2, 3'd3, 3'd1, 3'd0, 3'd5, 3'd4, 3'd6, 3'd7},
        '{3'd6, 3'd1, 3'd7, 3'd0, 3'd5, 3'd2, 3'd4, 3'd3},
        '{3'd2, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd0, 3'd7},
        '{3'd6, 3'd7, 3'd5, 3'd4, 3'd1, 3'd0, 3'd2, 3'd3},
        '{3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5},
        '{3'd4, 3'd7, 3'd3, 3'd0, 3'd5, 3'd6, 3'd2, 3'd1},
        '{3'd6, 3'd1, 3'd7, 3'd0, 3'd5, 3'd2, 3'd4, 3'd3},
        '{3'd4, 3'd3, 3'd7, 3'd0, 3'd5, 3'd4, 3'd2, 3'd1},
        '{3'd4, 3'd5, 3'd1, 3'd0, 3'd7, 3'd6, 3'd2, 3'd3}
    };

    // Hilbert walk table: next state, by state and octant
    localparam logic [STATE_W-1:0] HIL_NXT [HIL_STATES][8] = '{
        '{4'd1, 4'd2, 4'd2, 4'd5, 4'd4, 4'd5, 4'd4, 4'd1},
        '{4'd0, 4'd6, 4'd6, 4'd11, 4'd8, 4'd11, 4'd8, 4'd0},
        '{4'd0, 4'd7, 4'd7, 4'd9, 4'd10, 4'd9, 4'd10, 4'd0},
        '{4'd1, 4'd2, 4'd2, 4'd5, 4'd4, 4'd5, 4'd4, 4'd1},
        '{4'd0, 4'd6, 4'd6, 4'd11, 4'd8, 4'd11, 4'd8, 4'd0},
        '{4'd0, 4'd7, 4'd7, 4'd9, 4'd10, 4'd9, 4'd10, 4'd0},
        '{4'd3, 4'd2, 4'd2, 4'd5, 4'd4, 4'd5, 4'd4, 4'd3},
        '{4'd3, 4'd7, 4'd7, 4'd9, 4'd10, 4'd9, 4'd10, 4'd3},
        '{4'd3, 4'd7, 4'd7, 4'd9, 4'd10, 4'd9, 4'd10, 4'd3},
        '{4'd3, 4'd2, 4'd2, 4'd5, 4'd4, 4'd5, 4'd4, 4'd3},
        '{4'd0, 4'd6, 4'd6, 4'd11, 4'd8, 4'd11, 4'd8, 4'd0},
        '{4'd0, 4'd7, 4'd7, 4'd9, 4'd10, 4'd9, 4'd10, 4'd0}
    };

    // Word handed from one cell to the next
    typedef struct packed {
        logic                valid;
        logic [MODE_W-1:0]   mode;
        logic [LEVEL_W-1:0]  levels;
        logic [STATE_W-1:0]  st;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [CODE_W-1:0]   code;
    } t_cell;

endpackage

// ===== hdl/mhe_intf.sv =====
`timescale 1ns / 1ps

// Voxel coordinate channel
interface mhe_coord_if;
    logic                       valid;
    logic                       ready;
    logic [mhe_pkg::COORD_W-1:0] coord_first;
    logic [mhe_pkg::COORD_W-1:0] coord_second;
    logic [mhe_pkg::COORD_W-1:0] coord_third;

    modport source (output valid, coord_first, coord_second, coord_third, input ready);
    modport sink   (input valid, coord_first, coord_second, coord_third, output ready);
endinterface

// Curve code channel
interface mhe_code_if;
    logic                       valid;
    logic                       ready;
    logic [mhe_pkg::CODE_W-1:0] curve_code;

    modport source (output valid, curve_code, input ready);
    modport sink   (input valid, curve_code, output ready);
endinterface

// Configuration write channel
interface mhe_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mhe_pkg::INDEX_W-1:0] index;
    logic [mhe_pkg::DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/morton_hilbert_3d_encoder_top.sv =====
`timescale 1ns / 1ps

// 3D Morton / Hilbert curve encoder. Takes one voxel word per cycle when not stalled
// and returns one 63-bit curve code per voxel, in order. Coordinates pass through a
// chain of COORD_BITS cells, one per bit level from the top bit down. In Morton mode
// each cell appends the raw octant as three code bits; in Hilbert mode only cells
// below the level count add the table index; the last cell is the output register, and
// the whole chain stalls while the output word is not taken. Configuration registers
// (curve_mode, x/y/z_source, hilbert_bits) are written through the config channel,
// which is always ready, and must be changed only while no voxel is in flight.
module morton_hilbert_3d_encoder_top #(
    parameter int COORD_BITS = 21
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mhe_coord_if.sink   i_coord,
    mhe_code_if.source  o_code,
    mhe_cfg_if.sink     i_cfg
);

    logic [mhe_pkg::MODE_W-1:0]  r_curve_mode;
    logic [mhe_pkg::SEL_W-1:0]   r_x_source;
    logic [mhe_pkg::SEL_W-1:0]   r_y_source;
    logic [mhe_pkg::SEL_W-1:0]   r_z_source;
    logic [mhe_pkg::LEVEL_W-1:0] r_hilbert_bits;

    logic                        w_adv;
    logic [mhe_pkg::LEVEL_W-1:0] w_levels;
    logic [mhe_pkg::COORD_W-1:0] w_x;
    logic [mhe_pkg::COORD_W-1:0] w_y;
    logic [mhe_pkg::COORD_W-1:0] w_z;
    mhe_pkg::t_cell              w_chain [COORD_BITS+1];

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode   <= mhe_pkg::MODE_MORTON;
            r_x_source     <= mhe_pkg::SRC_FIRST;
            r_y_source     <= mhe_pkg::SRC_SECOND;
            r_z_source     <= mhe_pkg::SRC_THIRD;
            r_hilbert_bits <= 5'd10;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mhe_pkg::CFG_CURVE_MODE:   r_curve_mode   <= i_cfg.data[1:0];
                mhe_pkg::CFG_X_SOURCE:     r_x_source     <= i_cfg.data[1:0];
                mhe_pkg::CFG_Y_SOURCE:     r_y_source     <= i_cfg.data[1:0];
                mhe_pkg::CFG_Z_SOURCE:     r_z_source     <= i_cfg.data[1:0];
                mhe_pkg::CFG_HILBERT_BITS: r_hilbert_bits <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Pick the axes; an unused select reads as zero
    always_comb begin
        unique case (r_x_source)
            mhe_pkg::SRC_FIRST:  w_x = i_coord.coord_first;
            mhe_pkg::SRC_SECOND: w_x = i_coord.coord_second;
            mhe_pkg::SRC_THIRD:  w_x = i_coord.coord_third;
            default:             w_x = '0;
        endcase
        unique case (r_y_source)
            mhe_pkg::SRC_FIRST:  w_y = i_coord.coord_first;
            mhe_pkg::SRC_SECOND: w_y = i_coord.coord_second;
            mhe_pkg::SRC_THIRD:  w_y = i_coord.coord_third;
            default:             w_y = '0;
        endcase
        unique case (r_z_source)
            mhe_pkg::SRC_FIRST:  w_z = i_coord.coord_first;
            mhe_pkg::SRC_SECOND: w_z = i_coord.coord_second;
            mhe_pkg::SRC_THIRD:  w_z = i_coord.coord_third;
            default:             w_z = '0;
        endcase
    end

    // Saturate the Hilbert level count at the coordinate width
    assign w_levels = (r_hilbert_bits > 5'(COORD_BITS)) ? 5'(COORD_BITS) : r_hilbert_bits;

    // Chain moves whenever the output word is empty or being taken
    assign w_adv         = !o_code.valid || o_code.ready;
    assign i_coord.ready = w_adv;

    // Head word: walk starts in state zero with an empty code
    assign w_chain[0] = {i_coord.valid, r_curve_mode, w_levels,
                         {mhe_pkg::STATE_W{1'b0}}, w_x, w_y, w_z,
                         {mhe_pkg::CODE_W{1'b0}}};

    // One cell per bit level, top bit first
    for (genvar k = 0; k < COORD_BITS; k++) begin : g_cell
        mhe_cell #(
            .LEVEL (COORD_BITS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_word  (w_chain[k]),
            .o_word  (w_chain[k+1])
        );
    end

    assign o_code.valid      = w_chain[COORD_BITS].valid;
    assign o_code.curve_code = w_chain[COORD_BITS].code;

    // A disabled mode leaves the code empty
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_code.valid && w_chain[COORD_BITS].mode != mhe_pkg::MODE_MORTON &&
         w_chain[COORD_BITS].mode != mhe_pkg::MODE_HILBERT) |-> o_code.curve_code == '0)
        else $error("disabled mode produced a nonzero code");

    // Hilbert code holds no bits above its walked levels
    a_hil_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_code.valid && w_chain[COORD_BITS].mode == mhe_pkg::MODE_HILBERT) |->
        (o_code.curve_code >> (3 * w_chain[COORD_BITS].levels)) == '0)
        else $error("Hilbert code wider than its level count");

    // Walk state stays within the table
    a_hil_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_code.valid |-> w_chain[COORD_BITS].st < 4'(mhe_pkg::HIL_STATES))
        else $error("Hilbert walk state out of range");

    // Reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_code.valid)
        else $error("output valid after reset");

endmodule

// ===== hdl/mhe_cell.sv =====
`timescale 1ns / 1ps

// One bit level of the curve walk. Shifts three code bits in per Morton word, or per Hilbert word within the levels.
module mhe_cell #(
    parameter int LEVEL = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  mhe_pkg::t_cell i_word,
    output mhe_pkg::t_cell o_word
);

    mhe_pkg::t_cell r_word;
    mhe_pkg::t_cell n_word;
    logic [2:0]     w_oct;

    // Form the octant from this level's bit of each axis
    assign w_oct = {i_word.z[LEVEL], i_word.y[LEVEL], i_word.x[LEVEL]};

    // Append the octant or the table index, and step the walk state
    always_comb begin
        n_word = i_word;
        if (i_word.mode == mhe_pkg::MODE_MORTON) begin
            n_word.code = {i_word.code[mhe_pkg::CODE_W-4:0], w_oct};
        end else if (i_word.mode == mhe_pkg::MODE_HILBERT &&
                     i_word.levels > 5'(LEVEL)) begin
            n_word.code = {i_word.code[mhe_pkg::CODE_W-4:0],
                           mhe_pkg::HIL_IDX[i_word.st][w_oct]};
            n_word.st   = mhe_pkg::HIL_NXT[i_word.st][w_oct];
        end
    end

    // Advance with the chain; hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_adv) begin
            r_word.valid <= n_word.valid;
        end
        if (i_adv) begin
            r_word.mode   <= n_word.mode;
            r_word.levels <= n_word.levels;
            r_word.st     <= n_word.st;
            r_word.x      <= n_word.x;
            r_word.y      <= n_word.y;
            r_word.z      <= n_word.z;
            r_word.code   <= n_word.code;
        end
    end

    assign o_word = r_word;

endmodule

// ===== bench/curve_code_checker.sv =====
`timescale 1ns / 1ps

module curve_code_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mhe_coord_if   coord_mon,
    mhe_code_if    code_mon,
    mhe_cfg_if     cfg_mon,
    output int     o_errors,
    output int     o_pending
);

    localparam int LEVELS_MAX = 21;

    // Octant walk: emitted index per state and octant
    localparam logic [2:0] WALK_INDEX [12][8] = '{
        '{3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5},
        '{3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd5},
        '{3'd0, 3'd3, 3'd7, 3'd4, 3'd1, 3'd2, 3'd6, 3'd5},
        '{3'd2, 3'd3, 3'd1, 3'd0, 3'd5, 3'd4, 3'd6, 3'd7},
        '{3'd6, 3'd1, 3'd7, 3'd0, 3'd5, 3'd2, 3'd4, 3'd3},
        '{3'd2, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd0, 3'd7},
        '{3'd6, 3'd7, 3'd5, 3'd4, 3'd1, 3'd0, 3'd2, 3'd3},
        '{3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5},
        '{3'd4, 3'd7, 3'd3, 3'd0, 3'd5, 3'd6, 3'd2, 3'd1},
        '{3'd6, 3'd1, 3'd7, 3'd0, 3'd5, 3'd2, 3'd4, 3'd3},
        '{3'd4, 3'd3, 3'd7, 3'd0, 3'd5, 3'd4, 3'd2, 3'd1},
        '{3'd4, 3'd5, 3'd1, 3'd0, 3'd7, 3'd6, 3'd2, 3'd3}
    };

    // Octant walk: following state per state and octant
    localparam logic [3:0] WALK_NEXT [12][8] = '{
        '{4'd1, 4'd2, 4'd2, 4'd5,  4'd4,  4'd5,  4'd4,  4'd1},
        '{4'd0, 4'd6, 4'd6, 4'd11, 4'd8,  4'd11, 4'd8,  4'd0},
        '{4'd0, 4'd7, 4'd7, 4'd9,  4'd10, 4'd9,  4'd10, 4'd0},
        '{4'd1, 4'd2, 4'd2, 4'd5,  4'd4,  4'd5,  4'd4,  4'd1},
        '{4'd0, 4'd6, 4'd6, 4'd11, 4'd8,  4'd11, 4'd8,  4'd0},
        '{4'd0, 4'd7, 4'd7, 4'd9,  4'd10, 4'd9,  4'd10, 4'd0},
        '{4'd3, 4'd2, 4'd2, 4'd5,  4'd4,  4'd5,  4'd4,  4'd3},
        '{4'd3, 4'd7, 4'd7, 4'd9,  4'd10, 4'd9,  4'd10, 4'd3},
        '{4'd3, 4'd7, 4'd7, 4'd9,  4'd10, 4'd9,  4'd10, 4'd3},
        '{4'd3, 4'd2, 4'd2, 4'd5,  4'd4,  4'd5,  4'd4,  4'd3},
        '{4'd0, 4'd6, 4'd6, 4'd11, 4'd8,  4'd11, 4'd8,  4'd0},
        '{4'd0, 4'd7, 4'd7, 4'd9,  4'd10, 4'd9,  4'd10, 4'd0}
    };

    // Shadow copy of the configuration registers
    logic [mhe_pkg::MODE_W-1:0]  curve_mode;
    logic [mhe_pkg::SEL_W-1:0]   x_sel;
    logic [mhe_pkg::SEL_W-1:0]   y_sel;
    logic [mhe_pkg::SEL_W-1:0]   z_sel;
    logic [mhe_pkg::LEVEL_W-1:0] hilbert_levels;

    logic [mhe_pkg::CODE_W-1:0]  expected_codes [$];
    int                          error_count = 0;

    assign o_errors = error_count;

    function automatic logic [mhe_pkg::COORD_W-1:0] axis_value(
        logic [mhe_pkg::SEL_W-1:0] sel, logic [mhe_pkg::COORD_W-1:0] c0,
        logic [mhe_pkg::COORD_W-1:0] c1, logic [mhe_pkg::COORD_W-1:0] c2);
        case (sel)
            mhe_pkg::SRC_FIRST:  return c0;
            mhe_pkg::SRC_SECOND: return c1;
            mhe_pkg::SRC_THIRD:  return c2;
            default:             return '0;
        endcase
    endfunction

    // Work out the code for one voxel under the current settings
    function automatic logic [mhe_pkg::CODE_W-1:0] encode_voxel(
        logic [mhe_pkg::COORD_W-1:0] c0, logic [mhe_pkg::COORD_W-1:0] c1,
        logic [mhe_pkg::COORD_W-1:0] c2);
        logic [mhe_pkg::COORD_W-1:0] x;
        logic [mhe_pkg::COORD_W-1:0] y;
        logic [mhe_pkg::COORD_W-1:0] z;
        logic [mhe_pkg::CODE_W-1:0]  code;
        logic [2:0]                  oct;
        logic [3:0]                  st;
        int                          lv;
        x = axis_value(x_sel, c0, c1, c2);
        y = axis_value(y_sel, c0, c1, c2);
        z = axis_value(z_sel, c0, c1, c2);
        code = '0;
        st = '0;
        if (curve_mode == mhe_pkg::MODE_MORTON) begin
            for (int i = 0; i < mhe_pkg::COORD_W; i++) begin
                code[3*i]   = x[i];
                code[3*i+1] = y[i];
                code[3*i+2] = z[i];
            end
        end else if (curve_mode == mhe_pkg::MODE_HILBERT) begin
            lv = (hilbert_levels > LEVELS_MAX) ? LEVELS_MAX : int'(hilbert_levels);
            for (int b = lv - 1; b >= 0; b--) begin
                oct = {z[b], y[b], x[b]};
                code = {code[mhe_pkg::CODE_W-4:0], WALK_INDEX[st][oct]};
                st = WALK_NEXT[st][oct];
            end
        end
        return code;
    endfunction

    // Track settings, queue predictions, compare returned codes
    always @(posedge i_clk) begin : track
        logic [mhe_pkg::CODE_W-1:0] want;
        if (!i_rst_n) begin
            curve_mode     = mhe_pkg::MODE_MORTON;
            x_sel          = mhe_pkg::SRC_FIRST;
            y_sel          = mhe_pkg::SRC_SECOND;
            z_sel          = mhe_pkg::SRC_THIRD;
            hilbert_levels = 5'd10;
            expected_codes.delete();
        end else begin
            // Retire the oldest prediction before queuing a new one
            if (code_mon.valid && code_mon.ready) begin
                if (expected_codes.size() == 0) begin
                    if (error_count < 10)
                        $display("%0t: code %h returned with none pending",
                                 $realtime, code_mon.curve_code);
                    error_count++;
                end else begin
                    want = expected_codes.pop_front();
                    if (code_mon.curve_code !== want) begin
                        if (error_count < 10)
                            $display("%0t: curve_code expected %h actual %h",
                                     $realtime, want, code_mon.curve_code);
                        error_count++;
                    end
                end
            end
            if (coord_mon.valid && coord_mon.ready)
                expected_codes.push_back(encode_voxel(coord_mon.coord_first,
                                                      coord_mon.coord_second,
                                                      coord_mon.coord_third));
            // A register write takes effect after the word taken on this edge
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.index)
                    mhe_pkg::CFG_CURVE_MODE:
                        curve_mode = cfg_mon.data[mhe_pkg::MODE_W-1:0];
                    mhe_pkg::CFG_X_SOURCE:
                        x_sel = cfg_mon.data[mhe_pkg::SEL_W-1:0];
                    mhe_pkg::CFG_Y_SOURCE:
                        y_sel = cfg_mon.data[mhe_pkg::SEL_W-1:0];
                    mhe_pkg::CFG_Z_SOURCE:
                        z_sel = cfg_mon.data[mhe_pkg::SEL_W-1:0];
                    mhe_pkg::CFG_HILBERT_BITS:
                        hilbert_levels = cfg_mon.data;
                    default: ;
                endcase
            end
        end
        o_pending <= expected_codes.size();
    end

endmodule

// ===== bench/morton_hilbert_3d_encoder_top_tb.sv =====
`timescale 1ns / 1ps

module morton_hilbert_3d_encoder_top_tb;

    localparam int                           DEPTH      = 21;
    localparam logic [mhe_pkg::COORD_W-1:0]  CMAX       = 21'h1FFFFF;
    localparam logic [mhe_pkg::MODE_W-1:0]   MODE_OFF   = 2'd2;
    localparam logic [mhe_pkg::MODE_W-1:0]   MODE_SPARE = 2'd3;
    localparam logic [mhe_pkg::SEL_W-1:0]    SRC_NONE   = 2'd3;
    localparam logic [mhe_pkg::INDEX_W-1:0]  CFG_UNUSED = 3'd5;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   sender_idle_pct   = 0;
    int   receiver_stall_pct = 0;

    mhe_coord_if coord_ch ();
    mhe_code_if  code_ch ();
    mhe_cfg_if   cfg_ch ();

    morton_hilbert_3d_encoder_top #(.COORD_BITS(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coord (coord_ch),
        .o_code  (code_ch),
        .i_cfg   (cfg_ch)
    );

    curve_code_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .coord_mon (coord_ch),
        .code_mon  (code_ch),
        .cfg_mon   (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stall the code channel at random
    initial begin
        code_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            code_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        #(64'd7_200_000);
        $display("morton_hilbert_3d_encoder_top: mismatch");
        $finish;
    end

    // Send one voxel word, with random idle cycles ahead of it
    task automatic send_voxel(logic [mhe_pkg::COORD_W-1:0] c0,
                              logic [mhe_pkg::COORD_W-1:0] c1,
                              logic [mhe_pkg::COORD_W-1:0] c2);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            coord_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        coord_ch.valid        <= 1'b1;
        coord_ch.coord_first  <= c0;
        coord_ch.coord_second <= c1;
        coord_ch.coord_third  <= c2;
        do @(posedge i_clk); while (!coord_ch.ready);
    endtask

    // Drop valid and hold until every voxel has come back
    task automatic drain_codes();
        @(negedge i_clk);
        coord_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [mhe_pkg::INDEX_W-1:0] idx,
                             logic [mhe_pkg::DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(logic [mhe_pkg::DATA_W-1:0] mode,
                              logic [mhe_pkg::DATA_W-1:0] xs,
                              logic [mhe_pkg::DATA_W-1:0] ys,
                              logic [mhe_pkg::DATA_W-1:0] zs,
                              logic [mhe_pkg::DATA_W-1:0] levels);
        drain_codes();
        write_reg(mhe_pkg::CFG_CURVE_MODE, mode);
        write_reg(mhe_pkg::CFG_X_SOURCE, xs);
        write_reg(mhe_pkg::CFG_Y_SOURCE, ys);
        write_reg(mhe_pkg::CFG_Z_SOURCE, zs);
        write_reg(mhe_pkg::CFG_HILBERT_BITS, levels);
    endtask

    // Write mode and axis selects with clean upper data bits
    task automatic set_mode_axes(logic [mhe_pkg::MODE_W-1:0] mode,
                                 logic [mhe_pkg::SEL_W-1:0] xs,
                                 logic [mhe_pkg::SEL_W-1:0] ys,
                                 logic [mhe_pkg::SEL_W-1:0] zs,
                                 logic [mhe_pkg::DATA_W-1:0] levels);
        set_config({3'b000, mode}, {3'b000, xs}, {3'b000, ys}, {3'b000, zs}, levels);
    endtask

    function automatic logic [mhe_pkg::SEL_W-1:0] random_source();
        if ($urandom_range(11) == 0)
            return SRC_NONE;
        return 2'($urandom_range(2));
    endfunction

    // Draw a setting; junk in the upper data bits must be ignored
    task automatic set_random_config();
        logic [mhe_pkg::MODE_W-1:0]  mode;
        logic [mhe_pkg::LEVEL_W-1:0] levels;
        int                          pick;
        pick = $urandom_range(9);
        if (pick < 4)
            mode = mhe_pkg::MODE_MORTON;
        else if (pick < 8)
            mode = mhe_pkg::MODE_HILBERT;
        else if (pick == 8)
            mode = MODE_OFF;
        else
            mode = MODE_SPARE;
        case ($urandom_range(7))
            0:       levels = 5'd0;
            1:       levels = 5'd1;
            2:       levels = 5'd21;
            3:       levels = 5'd31;
            4:       levels = 5'($urandom_range(22, 30));
            default: levels = 5'($urandom_range(2, 20));
        endcase
        set_config({3'($urandom_range(7)), mode},
                   {3'($urandom_range(7)), random_source()},
                   {3'($urandom_range(7)), random_source()},
                   {3'($urandom_range(7)), random_source()},
                   levels);
        if ($urandom_range(5) == 0)
            write_reg(CFG_UNUSED, 5'($urandom_range(31)));
    endtask

    function automatic logic [mhe_pkg::COORD_W-1:0] random_coord();
        logic [mhe_pkg::COORD_W-1:0] one_hot;
        one_hot = 21'd1 << $urandom_range(20);
        case ($urandom_range(9))
            0:       return '0;
            1:       return CMAX;
            2:       return 21'($urandom_range(15));
            3:       return one_hot;
            4:       return CMAX ^ one_hot;
            default: return 21'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        int sender_pcts   [4] = '{0, 88, 0, 26};
        int receiver_pcts [4] = '{0, 0, 88, 26};
        int wait_cycles;
        i_rst_n               = 1'b0;
        coord_ch.valid        = 1'b0;
        coord_ch.coord_first  = '0;
        coord_ch.coord_second = '0;
        coord_ch.coord_third  = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = mhe_pkg::CFG_CURVE_MODE;
        cfg_ch.data           = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Morton under reset settings: extremes and bit patterns
        send_voxel('0, '0, '0);
        send_voxel(CMAX, CMAX, CMAX);
        send_voxel(CMAX, '0, '0);
        send_voxel('0, CMAX, '0);
        send_voxel('0, '0, CMAX);
        send_voxel(21'h155555, 21'h0AAAAA, 21'h100001);
        send_voxel(21'h100000, 21'h000001, 21'h0F0F0F);

        // Hilbert over all levels
        set_mode_axes(mhe_pkg::MODE_HILBERT, mhe_pkg::SRC_FIRST, mhe_pkg::SRC_SECOND,
                      mhe_pkg::SRC_THIRD, 5'd21);
        send_voxel('0, '0, '0);
        send_voxel(CMAX, CMAX, CMAX);
        send_voxel(21'h155555, 21'h0AAAAA, 21'h1C71C7);
        send_voxel(21'h123456, 21'h0FEDCB, 21'h1A5A5A);

        // Zero levels, saturated levels, a single level
        set_mode_axes(mhe_pkg::MODE_HILBERT, mhe_pkg::SRC_FIRST, mhe_pkg::SRC_SECOND,
                      mhe_pkg::SRC_THIRD, 5'd0);
        send_voxel(CMAX, CMAX, CMAX);
        set_mode_axes(mhe_pkg::MODE_HILBERT, mhe_pkg::SRC_FIRST, mhe_pkg::SRC_SECOND,
                      mhe_pkg::SRC_THIRD, 5'd31);
        send_voxel(21'h1ABCDE, 21'h054321, 21'h1FFFF0);
        set_mode_axes(mhe_pkg::MODE_HILBERT, mhe_pkg::SRC_FIRST, mhe_pkg::SRC_SECOND,
                      mhe_pkg::SRC_THIRD, 5'd1);
        send_voxel(CMAX, '0, CMAX);

        // Permuted axes
        set_mode_axes(mhe_pkg::MODE_HILBERT, mhe_pkg::SRC_THIRD, mhe_pkg::SRC_FIRST,
                      mhe_pkg::SRC_SECOND, 5'd10);
        send_voxel(21'h0003FF, 21'h000155, 21'h0002AA);

        // Disabled mode and the spare mode code
        set_mode_axes(MODE_OFF, mhe_pkg::SRC_FIRST, mhe_pkg::SRC_SECOND,
                      mhe_pkg::SRC_THIRD, 5'd21);
        send_voxel(CMAX, CMAX, CMAX);
        set_config({3'b111, MODE_SPARE}, {3'b000, mhe_pkg::SRC_FIRST},
                   {3'b000, mhe_pkg::SRC_SECOND}, {3'b000, mhe_pkg::SRC_THIRD}, 5'd21);
        send_voxel(CMAX, CMAX, CMAX);

        // Unused source select reads zero
        set_mode_axes(mhe_pkg::MODE_MORTON, SRC_NONE, mhe_pkg::SRC_THIRD, SRC_NONE, 5'd10);
        send_voxel(CMAX, 21'h0F0F0F, CMAX);

        // A write to an unused index changes nothing
        drain_codes();
        write_reg(CFG_UNUSED, 5'h1F);
        send_voxel(21'h13579B, 21'h02468A, 21'h1DCBA9);

        // Random settings and voxels under each idle pattern
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = sender_pcts[p];
            receiver_stall_pct = receiver_pcts[p];
            for (int k = 0; k < 6; k++) begin
                set_random_config();
                repeat (60) send_voxel(random_coord(), random_coord(), random_coord());
            end
        end

        // Let the pipeline empty, then allow for its depth
        @(negedge i_clk);
        coord_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 50000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (DEPTH + 4) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("morton_hilbert_3d_encoder_top: match");
        else
            $display("morton_hilbert_3d_encoder_top: mismatch");
        $finish;
    end

endmodule
